// ----- design/form_field_extract_decode_macros.svh -----
// assertion macros used by the checker file
`ifndef FORM_FIELD_EXTRACT_DECODE_MACROS_SVH
`define FORM_FIELD_EXTRACT_DECODE_MACROS_SVH

// same-cycle implication, off while reset is high
`define FFD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffd check failed: same-cycle implication");

// next-cycle implication, off while reset is high
`define FFD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffd check failed: next-cycle implication");

// next-cycle implication that also holds across reset
`define FFD_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ffd check failed: next-cycle implication across reset");

`endif

// ----- design/ffd_pkg.sv -----
// ----------------------------------------------------------------------------
// ffd_pkg
// shared types, constants and helper functions of the form field decoder
// ----------------------------------------------------------------------------
package ffd_pkg;

   // field name storage
   localparam int MAX_NAME_BYTES  = 8;
   localparam int NAME_WIDTH      = 8 * MAX_NAME_BYTES;
   localparam int LEN_WIDTH       = 4;
   localparam int RECENT_DEPTH    = MAX_NAME_BYTES + 2;

   // saturating byte position
   localparam int                 POS_WIDTH = 4;
   localparam logic [POS_WIDTH-1:0] POS_MAX  = 4'd15;

   // results per transaction and queue sizing
   localparam int MAX_RESULTS     = 4;
   localparam int RES_IDX_WIDTH   = 2;
   localparam int RES_CNT_WIDTH   = 3;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;
   localparam int QUEUE_CNT_WIDTH = 3;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIELD_NAME  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NAME_LENGTH = 2'd1;

   // characters of interest
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;

   typedef logic [7:0] byte_type;

   // all results caused by one body byte
   typedef struct packed {
      byte_type [MAX_RESULTS-1:0] data;
      logic [RES_CNT_WIDTH-1:0]   count;
      logic                       is_end;
      logic                       found;
   } entry_type;

   // 0-9, A-F, a-f only
   function automatic logic hex_valid(input byte_type c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   // nibble of a valid hex digit: letters sit at low nibble plus nine
   function automatic logic [3:0] hex_value(input byte_type c);
      logic [3:0] v;
      if (c[6]) begin
         v = c[3:0] + 4'd9;
      end else begin
         v = c[3:0];
      end
      return v;
   endfunction

endpackage

// ----- design/ffd_if.sv -----
// ----------------------------------------------------------------------------
// ffd channel interfaces
// body byte request, decoded result and register write channels
// ----------------------------------------------------------------------------

// body byte channel
interface ffd_req_if import ffd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type body_byte;
   logic     body_last;

   modport source (output valid, output body_byte, output body_last, input ready);
   modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

// decoded result channel
interface ffd_rsp_if import ffd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type value_byte;
   logic     byte_valid;
   logic     field_found;
   logic     end_of_body;

   modport source (output valid, output value_byte, output byte_valid,
                   output field_found, output end_of_body, input ready);
   modport sink   (input valid, input value_byte, input byte_valid,
                   input field_found, input end_of_body, output ready);
endinterface

// register write channel
interface ffd_csr_if import ffd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/ffd_front.sv -----
// ----------------------------------------------------------------------------
// ffd_front
// accepts body bytes, matches the field name and decodes the value bytes
// into at most one queue entry per transaction
// ----------------------------------------------------------------------------
module ffd_front import ffd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ffd_req_if.sink   req_if,
   ffd_csr_if.sink   csr_if,
   output logic      push_valid,
   output entry_type push_entry,
   input  logic      push_ready
);

   // phase codes
   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_VALUE  = 2'd1;
   localparam logic [1:0] PH_SKIP   = 2'd2;

   // escape progress codes
   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_ONE  = 2'd1;
   localparam logic [1:0] ESC_TWO  = 2'd2;

   logic [NAME_WIDTH-1:0] name_ff;
   logic [LEN_WIDTH-1:0]  len_ff;
   logic [LEN_WIDTH-1:0]  eff_len;

   byte_type               recent_ff [RECENT_DEPTH-1];
   byte_type               recent_in [RECENT_DEPTH-1];
   byte_type               shifted   [RECENT_DEPTH];
   logic [POS_WIDTH-1:0]   pos_ff, pos_in, pos_next;
   logic [1:0]             phase_ff, phase_in;
   logic [1:0]             esc_ff, esc_in;
   byte_type               pend_ff, pend_in;
   logic                   match_ff, match_in;

   logic                   name_hit;
   logic                   eq_hit;
   logic                   at_boundary;
   logic                   accept;
   byte_type [MAX_RESULTS-1:0] res_data;
   logic [RES_CNT_WIDTH-1:0]   res_cnt;

   // register writes, always taken
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff <= '0;
         len_ff  <= LEN_WIDTH'(1);
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_FIELD_NAME:  name_ff <= csr_if.data[NAME_WIDTH-1:0];
            CSR_NAME_LENGTH: len_ff  <= csr_if.data[LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // length clamped to the name storage
   assign eff_len = (len_ff > LEN_WIDTH'(MAX_NAME_BYTES)) ?
                    LEN_WIDTH'(MAX_NAME_BYTES) : len_ff;

   // history with the new byte shifted in
   always_comb begin
      shifted[0] = req_if.body_byte;
      for (int j = 1; j < RECENT_DEPTH; j++) begin
         shifted[j] = recent_ff[j-1];
      end
   end

   assign pos_next = (pos_ff < POS_MAX) ? pos_ff + POS_WIDTH'(1) : pos_ff;

   // name compare, one lane per name byte
   always_comb begin
      logic [LEN_WIDTH-1:0] idx;
      name_hit = 1'b1;
      for (int k = 0; k < MAX_NAME_BYTES; k++) begin
         idx = eff_len - LEN_WIDTH'(k);
         if ((LEN_WIDTH'(k) < eff_len) && (shifted[idx] != name_ff[8*k +: 8])) begin
            name_hit = 1'b0;
         end
      end
   end

   assign eq_hit = (req_if.body_byte == CHAR_EQUAL) && name_hit &&
                   !(pos_next < (eff_len + LEN_WIDTH'(1)));
   assign at_boundary = (pos_next == (eff_len + LEN_WIDTH'(1))) ||
                        (shifted[eff_len + LEN_WIDTH'(1)] == CHAR_AMP);

   // classify the byte and collect its results
   always_comb begin
      logic do_plain;
      recent_in = recent_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      esc_in    = esc_ff;
      pend_in   = pend_ff;
      match_in  = match_ff;
      res_data  = '0;
      res_cnt   = '0;
      do_plain  = 1'b0;

      unique case (phase_ff)
         PH_SEARCH: begin
            for (int j = 0; j < RECENT_DEPTH - 1; j++) begin
               recent_in[j] = shifted[j];
            end
            pos_in = pos_next;
            if (eq_hit) begin
               if (at_boundary) begin
                  match_in = 1'b1;
                  phase_in = PH_VALUE;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_VALUE: begin
            if (esc_ff == ESC_ONE) begin
               if (hex_valid(req_if.body_byte)) begin
                  pend_in = req_if.body_byte;
                  esc_in  = ESC_TWO;
               end else begin
                  res_data[res_cnt[RES_IDX_WIDTH-1:0]] = CHAR_PERCENT;
                  res_cnt  = res_cnt + RES_CNT_WIDTH'(1);
                  esc_in   = ESC_NONE;
                  do_plain = 1'b1;
               end
            end else if (esc_ff == ESC_TWO) begin
               if (hex_valid(req_if.body_byte) && hex_valid(pend_ff)) begin
                  res_data[res_cnt[RES_IDX_WIDTH-1:0]] =
                     {hex_value(pend_ff), hex_value(req_if.body_byte)};
                  res_cnt = res_cnt + RES_CNT_WIDTH'(1);
                  esc_in  = ESC_NONE;
               end else begin
                  res_data[res_cnt[RES_IDX_WIDTH-1:0]] = CHAR_PERCENT;
                  res_cnt = res_cnt + RES_CNT_WIDTH'(1);
                  res_data[res_cnt[RES_IDX_WIDTH-1:0]] = pend_ff;
                  res_cnt  = res_cnt + RES_CNT_WIDTH'(1);
                  esc_in   = ESC_NONE;
                  do_plain = 1'b1;
               end
            end else begin
               esc_in   = ESC_NONE;
               do_plain = 1'b1;
            end

            // plain value byte
            if (do_plain) begin
               priority if (req_if.body_byte == CHAR_AMP) begin
                  phase_in = PH_SKIP;
               end else if (req_if.body_byte == CHAR_PLUS) begin
                  res_data[res_cnt[RES_IDX_WIDTH-1:0]] = CHAR_SPACE;
                  res_cnt = res_cnt + RES_CNT_WIDTH'(1);
               end else if (req_if.body_byte == CHAR_PERCENT) begin
                  esc_in = ESC_ONE;
               end else begin
                  res_data[res_cnt[RES_IDX_WIDTH-1:0]] = req_if.body_byte;
                  res_cnt = res_cnt + RES_CNT_WIDTH'(1);
               end
            end
         end
         default: ;
      endcase

      // body end: flush a cut-off escape, add the end record, clear state
      if (req_if.body_last) begin
         if (phase_in == PH_VALUE) begin
            if (esc_in == ESC_ONE) begin
               res_data[res_cnt[RES_IDX_WIDTH-1:0]] = CHAR_PERCENT;
               res_cnt = res_cnt + RES_CNT_WIDTH'(1);
            end else if (esc_in == ESC_TWO) begin
               res_data[res_cnt[RES_IDX_WIDTH-1:0]] = CHAR_PERCENT;
               res_cnt = res_cnt + RES_CNT_WIDTH'(1);
               res_data[res_cnt[RES_IDX_WIDTH-1:0]] = pend_in;
               res_cnt = res_cnt + RES_CNT_WIDTH'(1);
            end
         end
         res_cnt   = res_cnt + RES_CNT_WIDTH'(1);
         for (int j = 0; j < RECENT_DEPTH - 1; j++) begin
            recent_in[j] = '0;
         end
         pos_in    = '0;
         phase_in  = PH_SEARCH;
         esc_in    = ESC_NONE;
         pend_in   = '0;
      end
   end

   // queue push
   assign req_if.ready       = push_ready;
   assign accept             = req_if.valid && push_ready;
   assign push_valid         = req_if.valid && (res_cnt != '0);
   assign push_entry.data    = res_data;
   assign push_entry.count   = res_cnt;
   assign push_entry.is_end  = req_if.body_last;
   assign push_entry.found   = match_in;

   // body state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < RECENT_DEPTH - 1; j++) begin
            recent_ff[j] <= '0;
         end
         pos_ff   <= '0;
         phase_ff <= PH_SEARCH;
         esc_ff   <= ESC_NONE;
         pend_ff  <= '0;
         match_ff <= 1'b0;
      end else if (accept) begin
         recent_ff <= recent_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         esc_ff    <= esc_in;
         pend_ff   <= pend_in;
         match_ff  <= req_if.body_last ? 1'b0 : match_in;
      end
   end

endmodule

// ----- design/ffd_queue.sv -----
// ----------------------------------------------------------------------------
// ffd_queue
// short entry queue that decouples byte intake from result delivery
// ----------------------------------------------------------------------------
module ffd_queue import ffd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      push_ready,
   output logic      head_valid,
   output entry_type head_entry,
   input  logic      pop
);

   entry_type                  slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;
   logic                       do_push;
   logic                       do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QUEUE_CNT_WIDTH'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QUEUE_CNT_WIDTH'(1);
         end
      end
   end

endmodule

// ----- design/ffd_back.sv -----
// ----------------------------------------------------------------------------
// ffd_back
// walks the results of the head queue entry onto the registered output
// ----------------------------------------------------------------------------
module ffd_back import ffd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head_entry,
   output logic      pop,
   ffd_rsp_if.source rsp_if
);

   logic                     rsp_valid_ff;
   byte_type                 value_ff;
   logic                     byte_valid_ff;
   logic                     found_ff;
   logic                     end_ff;
   logic [RES_IDX_WIDTH-1:0] sub_ff;

   logic load;
   logic take;
   logic last_of_entry;
   logic end_rec;

   // output register is free or being drained
   assign load          = !rsp_valid_ff || rsp_if.ready;
   assign take          = load && head_valid;
   assign last_of_entry = (({1'b0, sub_ff} + RES_CNT_WIDTH'(1)) == head_entry.count);
   assign end_rec       = head_entry.is_end && last_of_entry;
   assign pop           = take && last_of_entry;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= '0;
      end else if (load) begin
         rsp_valid_ff <= head_valid;
         if (take) begin
            sub_ff <= last_of_entry ? '0 : sub_ff + RES_IDX_WIDTH'(1);
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         value_ff      <= end_rec ? '0 : head_entry.data[sub_ff];
         byte_valid_ff <= !end_rec;
         found_ff      <= end_rec && head_entry.found;
         end_ff        <= end_rec;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.value_byte  = value_ff;
   assign rsp_if.byte_valid  = byte_valid_ff;
   assign rsp_if.field_found = found_ff;
   assign rsp_if.end_of_body = end_ff;

endmodule

// ----- design/form_field_extract_decode.sv -----
// ----------------------------------------------------------------------------
// form_field_extract_decode
// streams a urlencoded form body in one byte per transaction on req_if and
// returns the decoded value of the configured field on rsp_if, followed by
// one end record per body that tells whether the field was found.
// csr_if writes the field name (index 0) and its length (index 1); the user
// must write them only while idle, as the block itself does not enforce it.
// each result is registered in a queue slot and then in the output register.
// one body byte is taken per cycle while the queue has room. a byte yields
// at most 4 results (escape flushes and the end record), sent out in turn,
// and a four-entry queue between intake and output absorbs these bursts.
// when rsp_if stalls the result holds and intake goes on until the queue fills.
// reset clears body state and queue and sets name 0 with length 1.
// ----------------------------------------------------------------------------
module form_field_extract_decode import ffd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ffd_req_if.sink   req_if,
   ffd_rsp_if.source rsp_if,
   ffd_csr_if.sink   csr_if
);

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   // intake, name match and value decode
   ffd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // decoupling queue
   ffd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // result delivery
   ffd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

// ----- design/ffd_checker.sv -----
// ----------------------------------------------------------------------------
// ffd_checker
// port-level checks on the result channel of the form field decoder
// ----------------------------------------------------------------------------
`include "form_field_extract_decode_macros.svh"

module ffd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_value_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_field_found,
   input logic       rsp_end_of_body
);

   // stalled transaction holds
   `FFD_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_byte) && $stable(rsp_byte_valid) && $stable(rsp_field_found) && $stable(rsp_end_of_body))

   // every result is either a data byte or the end record
   `FFD_ASSERT_IMPLY(a_kind_exclusive, clock, reset, rsp_valid, (rsp_byte_valid != rsp_end_of_body) && !(rsp_byte_valid && rsp_field_found))

   // end record carries a zero value byte
   `FFD_ASSERT_IMPLY(a_end_clean, clock, reset, rsp_valid && rsp_end_of_body, rsp_value_byte == 8'h00)

   // nothing is offered right after reset
   `FFD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind form_field_extract_decode ffd_checker u_ffd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_value_byte  (rsp_if.value_byte),
   .rsp_byte_valid  (rsp_if.byte_valid),
   .rsp_field_found (rsp_if.field_found),
   .rsp_end_of_body (rsp_if.end_of_body)
);
